// ===== rtl/pjd_pkg.sv =====
// Package for the priority job dispatcher: widths, depths, job record type.
// No dependencies.
`default_nettype none
package pjd_pkg;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int MAX_CPUS_DEF    = 16;
    localparam int CPU_W           = 5;
    localparam int LIMIT_W         = 6;
    localparam logic [CPU_W-1:0] CPU_RESET = 5'd16;
    localparam int JOB_W           = 112;

    typedef struct packed {
        logic [31:0] duration;
        logic [15:0] importance;
        logic [31:0] submit_time;
        logic [31:0] job_id;
    } job_t;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_ASSIGN = 1'b1;

    // true if job a is served before job b (slot order breaks ties)
    function automatic logic job_ahead(job_t a, job_t b);
        logic r;
        if (a.importance != b.importance)
            r = a.importance > b.importance;
        else if (a.submit_time != b.submit_time)
            r = a.submit_time < b.submit_time;
        else
            r = a.duration < b.duration;
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/priority_job_dispatcher.sv =====
// Priority job dispatcher: waiting table and run table in RAMs, sequencer.
// Depends on pjd_pkg and pjd_ram.
//
// Channels: s_axis_* carries commands (submit or assign), m_axis_* carries
// results; an item moves when tvalid and tready are both high.
// cfg_we/cfg_wdata write the processor count (reset 16); write only while idle.
// Submit: one scan of the valid bits picks the lowest free slot, the job is
// written to the waiting RAM; no result unless the table is full, then one
// result with dropped = 1.
// Assign: a pass over the MAX_CPUS run-table RAM entries (one per cycle)
// retires finished jobs and counts busy processors. Then each dispatch
// is a pass over the QUEUE_DEPTH waiting entries through the one RAM read
// port, keeping the best job, followed by a write to a free run slot (for a
// nonzero duration) and an output item. The assign ends with a closing
// check once the limit is reached or no processor is free, or with a full
// pass that finds no job when the table has run empty.
// The result register is one deep; the block waits while the receiver
// stalls and does not lose results. Reset clears all valid bits and the
// sequencer; RAM contents are never used before they are written.
`default_nettype none
module priority_job_dispatcher
    import pjd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_CPUS    = MAX_CPUS_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_we,
    input  wire  [4:0]   cfg_wdata,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // [0] opcode [32:1] time_now [64:33] job_id [80:65] importance
    // [112:81] duration [118:113] assign_limit, zero fill to 120
    input  wire  [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [0] job_valid [1] dropped [33:2] out_job_id [65:34] out_submit_time
    // [81:66] out_importance [113:82] out_duration [145:114] completion_time
    // zero fill to 152
    output logic [151:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int RA_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int RD   = (MAX_CPUS > 1) ? MAX_CPUS : 2;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RC_W = $clog2(MAX_CPUS + 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RSCAN  = 7'b0000010,
        ST_QSCAN  = 7'b0000100,
        ST_DISP   = 7'b0001000,
        ST_OUT    = 7'b0010000,
        ST_SUBMIT = 7'b0100000,
        ST_DROP   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CPU_W-1:0] cpu_reg;
    logic [QUEUE_DEPTH-1:0] wvalid_reg;
    logic [RD-1:0] rvalid_reg;
    logic [31:0] now_reg;
    logic [LIMIT_W-1:0] limit_reg;
    job_t in_job_reg;
    logic [RC_W:0] ridx_reg;     // run scan counter, includes drain cycle
    logic [QC_W:0] qidx_reg;
    logic [RC_W-1:0] busy_reg;
    logic [LIMIT_W-1:0] sent_reg;
    logic have_reg;
    job_t best_reg;
    logic [QA_W-1:0] best_idx_reg;
    logic [QA_W-1:0] prev_idx_reg;
    logic prev_rd_reg;
    logic [151:0] out_data_reg;
    logic out_valid_reg, out_last_reg;

    // waiting RAM
    logic w_we;
    logic [QA_W-1:0] w_waddr, w_raddr;
    logic [JOB_W-1:0] w_rdata;
    job_t w_rjob;
    pjd_ram #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_wait (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(in_job_reg),
        .raddr(w_raddr), .rdata(w_rdata));
    assign w_rjob = job_t'(w_rdata);

    // run-table RAM
    logic r_we;
    logic [RA_W-1:0] r_waddr, r_raddr;
    logic [31:0] r_wdata, r_rdata;
    pjd_ram #(.WIDTH(32), .DEPTH(RD)) u_run (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata));

    // free slot search over valid bits
    logic w_full;
    logic [QA_W-1:0] w_free;
    always_comb
    begin
        w_full = 1'b1;
        w_free = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
            if (!wvalid_reg[i])
            begin
                w_full = 1'b0;
                w_free = QA_W'(i);
            end
    end
    logic [RA_W-1:0] r_free;
    always_comb
    begin
        r_free = '0;
        for (int i = RD - 1; i >= 0; i--)
            if (!rvalid_reg[i])
                r_free = RA_W'(i);
    end

    logic [CPU_W-1:0] cpus_eff;
    assign cpus_eff = (32'(cpu_reg) > MAX_CPUS) ? CPU_W'(MAX_CPUS) : cpu_reg;
    logic cpu_free;
    assign cpu_free = 32'(busy_reg) < 32'(cpus_eff);

    logic [32:0] done_sum;
    logic [31:0] done_t;
    assign done_sum = {1'b0, now_reg} + {1'b0, best_reg.duration};
    assign done_t   = done_sum[32] ? 32'hFFFF_FFFF : done_sum[31:0];

    logic out_free;
    assign out_free = !out_valid_reg || m_axis_tready;

    logic [RA_W-1:0] rprev;
    assign rprev = RA_W'(ridx_reg - 1'b1);
    logic [QA_W-1:0] qcur;
    assign qcur = qidx_reg[QA_W-1:0];

    logic out_load;
    assign out_load = ((state_reg == ST_DROP) || (state_reg == ST_OUT)) && out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign w_raddr = qcur;
    assign r_raddr = ridx_reg[RA_W-1:0];
    assign w_we    = (state_reg == ST_SUBMIT) && !w_full;
    assign w_waddr = w_free;
    assign r_we    = (state_reg == ST_DISP) && (best_reg.duration != 32'd0);
    assign r_waddr = r_free;
    assign r_wdata = done_t;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid)
                    state_next = (s_axis_tdata[0] == OP_SUBMIT) ? ST_SUBMIT : ST_RSCAN;
            ST_SUBMIT: state_next = w_full ? ST_DROP : ST_IDLE;
            ST_DROP:   if (out_free) state_next = ST_IDLE;
            ST_RSCAN:
                if (32'(ridx_reg) == MAX_CPUS)
                    state_next = ST_QSCAN;
            ST_QSCAN:
                if (32'(sent_reg) >= 32'(limit_reg) || !cpu_free)
                    state_next = ST_IDLE;
                else if (32'(qidx_reg) == QUEUE_DEPTH)
                    // last entry is still being compared in this cycle
                    state_next = (have_reg || prev_rd_reg) ? ST_DISP : ST_IDLE;
            ST_DISP:   state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_QSCAN;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cpu_reg       <= CPU_RESET;
            wvalid_reg    <= '0;
            rvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                cpu_reg <= cfg_wdata;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_SUBMIT:
                    if (!w_full)
                        wvalid_reg[w_free] <= 1'b1;
                ST_RSCAN:
                    if (ridx_reg != '0 && rvalid_reg[rprev] && r_rdata <= now_reg)
                        rvalid_reg[rprev] <= 1'b0;
                ST_DISP:
                begin
                    wvalid_reg[best_idx_reg] <= 1'b0;
                    if (best_reg.duration != 32'd0)
                        rvalid_reg[r_free] <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                now_reg    <= s_axis_tdata[32:1];
                in_job_reg <= job_t'({s_axis_tdata[112:81], s_axis_tdata[80:65],
                                      s_axis_tdata[32:1], s_axis_tdata[64:33]});
                limit_reg  <= (32'(s_axis_tdata[118:113]) > QUEUE_DEPTH)
                              ? LIMIT_W'(QUEUE_DEPTH) : s_axis_tdata[118:113];
                ridx_reg   <= '0;
                busy_reg   <= '0;
                sent_reg   <= '0;
                qidx_reg   <= '0;
                have_reg   <= 1'b0;
                prev_rd_reg <= 1'b0;
            end
            ST_DROP:
                if (out_free)
                begin
                    out_data_reg <= 152'd2;
                    out_last_reg <= 1'b1;
                end
            ST_RSCAN:
            begin
                ridx_reg <= ridx_reg + 1'b1;
                if (ridx_reg != '0 && rvalid_reg[rprev] && !(r_rdata <= now_reg))
                    busy_reg <= busy_reg + 1'b1;
            end
            ST_QSCAN:
            begin
                qidx_reg     <= qidx_reg + 1'b1;
                prev_idx_reg <= qcur;
                prev_rd_reg  <= (32'(qidx_reg) < QUEUE_DEPTH) && wvalid_reg[qcur];
                if (prev_rd_reg && (!have_reg || job_ahead(w_rjob, best_reg)))
                begin
                    have_reg     <= 1'b1;
                    best_reg     <= w_rjob;
                    best_idx_reg <= prev_idx_reg;
                end
            end
            ST_DISP:
                if (best_reg.duration != 32'd0)
                    busy_reg <= busy_reg + 1'b1;
            ST_OUT:
                if (out_free)
                begin
                    sent_reg    <= sent_reg + 1'b1;
                    qidx_reg    <= '0;
                    have_reg    <= 1'b0;
                    prev_rd_reg <= 1'b0;
                    out_data_reg <= {6'd0, done_t, best_reg.duration, best_reg.importance,
                                     best_reg.submit_time, best_reg.job_id, 2'b01};
                    // last if nothing more can follow
                    out_last_reg <= (32'(sent_reg) + 1 >= 32'(limit_reg)) || !cpu_free
                                    || (wvalid_reg == '0);
                end
            default: ;
        endcase
    end

    // result data and last flag are loaded only once the register is free
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
endmodule
`default_nettype wire

// ===== rtl/pjd_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pjd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/pjd_checker.sv =====
// Port-level checks for the priority job dispatcher, bound to the top.
// Depends on priority_job_dispatcher.
`default_nettype none
module pjd_checker (
    input wire         clk,
    input wire         rst_n,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [151:0] m_axis_tdata,
    input wire         m_axis_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[0] != m_axis_tdata[1])
        else $error("result neither job nor drop");
    a_droplast: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tlast)
        else $error("drop not last");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken mid burst");
endmodule

bind priority_job_dispatcher pjd_checker u_pjd_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast));
`default_nettype wire

// ===== sim/pjd_checker.sv =====
// Checker for the priority job dispatcher: watches config, command and result channels,
// keeps its own copy of the waiting and run tables, and compares every result item.
// Depends on pjd_pkg.
`timescale 1ns / 1ps
module pjd_scoreboard
    import pjd_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_we,
    input  wire  [4:0]   cfg_wdata,
    input  wire          s_axis_tvalid,
    input  wire          s_axis_tready,
    input  wire  [119:0] s_axis_tdata,
    input  wire          m_axis_tvalid,
    input  wire          m_axis_tready,
    input  wire  [151:0] m_axis_tdata,
    input  wire          m_axis_tlast,
    output int           errors,
    output int           pending
);
    localparam int SLOTS = 32;
    localparam int CPUS  = 16;

    typedef struct {
        logic        job_valid;
        logic        dropped;
        logic [31:0] id;
        logic [31:0] stime;
        logic [15:0] imp;
        logic [31:0] dur;
        logic [31:0] done;
        logic        last;
    } dispatch_t;

    dispatch_t   due_q[$];
    logic [4:0]  proc_count;
    logic        wt_used[SLOTS];
    job_t        wt_job[SLOTS];
    logic        rn_busy[CPUS];
    logic [31:0] rn_done[CPUS];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // slot a goes before slot b; equal jobs fall back to the lower slot
    function automatic logic served_first(int a, int b);
        logic r;
        if (wt_job[a].importance != wt_job[b].importance)
            r = wt_job[a].importance > wt_job[b].importance;
        else if (wt_job[a].submit_time != wt_job[b].submit_time)
            r = wt_job[a].submit_time < wt_job[b].submit_time;
        else if (wt_job[a].duration != wt_job[b].duration)
            r = wt_job[a].duration < wt_job[b].duration;
        else
            r = a < b;
        return r;
    endfunction

    task automatic take_command(input logic [119:0] d);
        int slot, best, sent, cpus, busy, room, lim;
        logic [31:0] now, fin;
        dispatch_t r;
        now = d[32:1];
        r = '{default: '0};
        if (d[0] == OP_SUBMIT) begin
            slot = -1;
            for (int i = 0; i < SLOTS; i++)
                if (!wt_used[i] && slot < 0)
                    slot = i;
            if (slot >= 0) begin
                wt_used[slot] = 1'b1;
                wt_job[slot].job_id = d[64:33];
                wt_job[slot].submit_time = now;
                wt_job[slot].importance = d[80:65];
                wt_job[slot].duration = d[112:81];
            end else begin
                r.dropped = 1'b1;
                r.last = 1'b1;
                due_q = {due_q, r};
            end
        end else begin
            lim = d[118:113];
            if (lim > SLOTS)
                lim = SLOTS;
            cpus = (proc_count > CPUS) ? CPUS : proc_count;
            busy = 0;
            for (int i = 0; i < CPUS; i++) begin
                if (rn_busy[i] && rn_done[i] <= now)
                    rn_busy[i] = 1'b0;
                if (rn_busy[i])
                    busy++;
            end
            room = (busy >= cpus) ? 0 : cpus - busy;
            sent = 0;
            while (sent < lim && room > 0) begin
                best = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (wt_used[i] && (best < 0 || served_first(i, best)))
                        best = i;
                if (best < 0)
                    break;
                fin = (wt_job[best].duration > 32'hFFFF_FFFF - now) ? 32'hFFFF_FFFF
                                                                    : now + wt_job[best].duration;
                wt_used[best] = 1'b0;
                if (wt_job[best].duration != 0) begin
                    for (int k = 0; k < CPUS; k++)
                        if (!rn_busy[k]) begin
                            rn_busy[k] = 1'b1;
                            rn_done[k] = fin;
                            break;
                        end
                    room--;
                end
                r.job_valid = 1'b1;
                r.id = wt_job[best].job_id;
                r.stime = wt_job[best].submit_time;
                r.imp = wt_job[best].importance;
                r.dur = wt_job[best].duration;
                r.done = fin;
                r.last = 1'b0;
                due_q = {due_q, r};
                sent++;
            end
            if (sent > 0)
                due_q[due_q.size() - 1].last = 1'b1;
        end
    endtask

    task automatic check_result(input logic [151:0] d, input logic tl);
        dispatch_t w;
        if (due_q.size() == 0) begin
            report("result with nothing expected", d[63:0], 0);
        end else begin
            w = due_q.pop_front();
            if (d[0] !== w.job_valid)       report("job_valid", d[0], w.job_valid);
            if (d[1] !== w.dropped)         report("dropped", d[1], w.dropped);
            if (d[33:2] !== w.id)           report("out_job_id", d[33:2], w.id);
            if (d[65:34] !== w.stime)       report("out_submit_time", d[65:34], w.stime);
            if (d[81:66] !== w.imp)         report("out_importance", d[81:66], w.imp);
            if (d[113:82] !== w.dur)        report("out_duration", d[113:82], w.dur);
            if (d[145:114] !== w.done)      report("completion_time", d[145:114], w.done);
            if (d[151:146] !== 6'd0)        report("fill bits", d[151:146], 0);
            if (tl !== w.last)              report("last", tl, w.last);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            proc_count <= CPU_RESET;
            for (int i = 0; i < SLOTS; i++)
                wt_used[i] = 1'b0;
            for (int i = 0; i < CPUS; i++)
                rn_busy[i] = 1'b0;
            due_q.delete();
            pending = 0;
            errors = 0;
        end else begin
            if (cfg_we)
                proc_count <= cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                take_command(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata, m_axis_tlast);
            pending = due_q.size();
        end
    end
endmodule

// ===== sim/priority_job_dispatcher_test.sv =====
// Testbench top for the priority job dispatcher: clock, reset, command stimulus,
// receiver back-pressure, watchdog and verdict. Depends on pjd_pkg, pjd_scoreboard and the RTL.
`timescale 1ns / 1ps
module priority_job_dispatcher_test;
    import pjd_pkg::*;

    localparam int QUIET_LIMIT = 20000;  // cycles with no item moving before giving up
    localparam int DRAIN       = 1300;   // wait long enough for the worst assign
    localparam int HOLD_CYCLES = 600;    // long receiver stall

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [4:0]   cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [151:0] m_axis_tdata;
    wire          m_axis_tlast;
    int           errors;
    int           pending;

    int           send_idle = 9;   // percent of cycles the sender sits out
    int           recv_idle = 80;  // percent of cycles the receiver stalls
    int           hold_asked = 0;
    int           hold_taken = 0;
    int           hold_left = 0;
    int           quiet = 0;
    logic [31:0]  clock_now = '0;  // running timestamp for commands

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    priority_job_dispatcher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    pjd_scoreboard chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .pending       (pending)
    );

    // Receiver: random stalls, or a long hold-off counted here when one is asked for.
    always @(negedge clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog: any accepted item on either channel resets the count.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // One command item; tvalid stays high into the next item when there is no gap.
    task automatic send_cmd(input logic op, input logic [31:0] t, input logic [31:0] id,
                            input logic [15:0] imp, input logic [31:0] dur,
                            input logic [5:0] lim);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        // fill, assign_limit, duration, importance, job_id, time_now, opcode
        s_axis_tdata <= {1'b0, lim, dur, imp, id, t, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Sender pause: every expected result in, then room for an assign that yields nothing.
    task automatic drain;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic set_cpus(input logic [4:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random command: mostly submits and assigns on a rising clock, sometimes a wild time.
    task automatic rand_cmd(input int submit_pct);
        logic [31:0] dur;
        logic [15:0] imp;
        logic [5:0]  lim;
        if ($urandom_range(15) == 0)
            clock_now = $urandom;
        else
            clock_now = clock_now + $urandom_range(0, 50);
        case ($urandom_range(7))
            0:       dur = '0;
            1:       dur = $urandom;
            2:       dur = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: dur = $urandom_range(1, 100);
        endcase
        imp = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        lim = ($urandom_range(7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 8));
        if ($urandom_range(99) < submit_pct)
            send_cmd(OP_SUBMIT, clock_now, $urandom, imp, dur, lim);
        else
            send_cmd(OP_ASSIGN, clock_now, $urandom, imp, dur, lim);
    endtask

    initial begin
        logic [4:0] cpu_steps[6];
        cpu_steps = '{5'd1, 5'd31, 5'd0, 5'd16, 5'd7, 5'd2};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, the tie-break chain, slot order on exact ties,
        // zero duration, saturated completion and the late release at the top time.
        send_cmd(OP_SUBMIT, 32'd0, 32'd0, 16'd0, 32'd0, 6'd0);
        send_cmd(OP_SUBMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F);
        send_cmd(OP_SUBMIT, 32'd10, 32'h11, 16'd5, 32'd30, 6'd0);
        send_cmd(OP_SUBMIT, 32'd10, 32'h12, 16'd5, 32'd20, 6'd0);
        send_cmd(OP_SUBMIT, 32'd9, 32'h13, 16'd5, 32'd40, 6'd0);
        send_cmd(OP_SUBMIT, 32'd10, 32'h14, 16'd5, 32'd20, 6'd0);
        send_cmd(OP_SUBMIT, 32'd10, 32'h15, 16'd6, 32'd1, 6'd0);
        send_cmd(OP_ASSIGN, 32'd20, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 6'd0);
        send_cmd(OP_ASSIGN, 32'd20, 32'd0, 16'd0, 32'd0, 6'd2);
        send_cmd(OP_ASSIGN, 32'd25, 32'd0, 16'd0, 32'd0, 6'h3F);
        send_cmd(OP_SUBMIT, 32'd30, 32'hA5A5_5A5A, 16'h8000, 32'd5, 6'd0);
        send_cmd(OP_ASSIGN, 32'd30, 32'd0, 16'd0, 32'd0, 6'd1);
        send_cmd(OP_ASSIGN, 32'hFFFF_FFFE, 32'd0, 16'd0, 32'd0, 6'd1);
        send_cmd(OP_SUBMIT, 32'd40, 32'h5A5A_A5A5, 16'h7FFF, 32'd2, 6'd0);
        send_cmd(OP_ASSIGN, 32'hFFFF_FFFF, 32'd0, 16'd0, 32'd0, 6'd32);
        send_cmd(OP_ASSIGN, 32'hFFFF_FFFF, 32'd0, 16'd0, 32'd0, 6'd33);
        clock_now = 32'd100;

        // Phases: new processor count each time, idling pattern changes every two.
        for (int p = 0; p < 6; p++) begin
            set_cpus(cpu_steps[p]);
            send_idle = (p < 2) ? 9 : (p < 4) ? 80 : 0;
            recv_idle = (p < 2) ? 80 : (p < 4) ? 9 : 0;
            if (p == 4)
                hold_asked++;
            // with no processor the table fills up and further submits are dropped
            if (p == 2)
                for (int i = 0; i < 36; i++)
                    rand_cmd(100);
            // twenty submits, then one assign with limit 32, while the receiver is held off
            if (p == 4) begin
                for (int i = 0; i < 20; i++)
                    rand_cmd(100);
                send_cmd(OP_ASSIGN, clock_now, 32'd0, 16'd0, 32'd0, 6'd32);
            end
            for (int i = 0; i < 15; i++)
                rand_cmd(60);
        end

        drain();
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
